// ===== hdl/scsc_pkg.sv =====
// Shared types and constants for the size class stack cache.
package scsc_pkg;

   localparam int SIZE_W      = 32;
   localparam int OUT_ADDR_W  = 48;
   localparam int CNT_W       = 32;
   localparam int ENTRIES_W   = 8;
   localparam int BYTES_W     = 40;
   localparam int OVH_W       = 16;
   localparam int CLASS_MAX_W = 4;

   localparam logic [OVH_W-1:0] OVH_RESET = 16'd256;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ALLOC_HIT      = 3'd0,
      ST_ALLOC_MISS     = 3'd1,
      ST_ALLOC_OVERSIZE = 3'd2,
      ST_FREE_CACHED    = 3'd3,
      ST_FREE_EVICT     = 3'd4,
      ST_FREE_OVERSIZE  = 3'd5
   } status_type;

   typedef struct packed {
      logic                   oversize;
      logic [CLASS_MAX_W-1:0] cls;
      logic [BYTES_W-1:0]     csize;
   } scsc_class_type;

   typedef struct packed {
      status_type            status;
      logic                  use_mem;
      logic [OUT_ADDR_W-1:0] pass_addr;
      logic [SIZE_W-1:0]     class_size;
      logic [CNT_W-1:0]      hits;
      logic [CNT_W-1:0]      misses;
      logic [ENTRIES_W-1:0]  entries;
      logic [BYTES_W-1:0]    bytes;
   } scsc_res_type;

endpackage

// ===== hdl/scsc_classify.sv =====
// Size rounding: oversize check, class index, rounded or raw size.
module scsc_classify
   import scsc_pkg::*;
#(
   parameter int MIN_SHIFT   = 12,
   parameter int NUM_CLASSES = 8
) (
   input  logic [SIZE_W-1:0] size,
   output scsc_class_type    cls_info
);

   localparam logic [63:0] MAX_POOLED = 64'd1 << (MIN_SHIFT + NUM_CLASSES - 1);

   logic [CLASS_MAX_W-1:0] cls_idx;
   logic                   oversize;

   always_comb begin
      cls_idx = '0;
      for (int i = 0; i < NUM_CLASSES - 1; i++) begin
         if ({32'b0, size} > (64'd1 << (MIN_SHIFT + i))) begin
            cls_idx = CLASS_MAX_W'(i + 1);
         end
      end
   end

   assign oversize = {32'b0, size} > MAX_POOLED;

   always_comb begin
      cls_info.oversize = oversize;
      cls_info.cls      = cls_idx;
      if (oversize) begin
         cls_info.csize = BYTES_W'(size);
      end else begin
         cls_info.csize = BYTES_W'(1) << (6'(MIN_SHIFT) + 6'(cls_idx));
      end
   end

endmodule

// ===== hdl/scsc_stack.sv =====
// Class stacks: fill counts, address memory, counters and the middle pipeline stage.
module scsc_stack
   import scsc_pkg::*;
#(
   parameter int NUM_CLASSES       = 8,
   parameter int ENTRIES_PER_CLASS = 16,
   parameter int ADDR_BITS         = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 item_valid,
   input  cmd_type              cmd,
   input  scsc_class_type       cls_info,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [OVH_W-1:0]     overhead,
   output logic [ADDR_BITS-1:0] rd_data,
   output scsc_res_type         res
);

   localparam int DEPTH  = NUM_CLASSES * ENTRIES_PER_CLASS;
   localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOT_W = (ENTRIES_PER_CLASS > 1) ? $clog2(ENTRIES_PER_CLASS) : 1;
   localparam int FILL_W = $clog2(ENTRIES_PER_CLASS + 1);
   localparam int ENT_W  = $clog2(DEPTH + 1);

   logic [ADDR_BITS-1:0] mem [DEPTH];
   logic [ADDR_BITS-1:0] rd_ff;

   logic [FILL_W-1:0] fill_ff [NUM_CLASSES];
   logic [CNT_W-1:0]  hits_ff, hits_in;
   logic [CNT_W-1:0]  misses_ff, misses_in;
   logic [ENT_W-1:0]  entries_ff, entries_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   scsc_res_type      res_ff, res_in;

   logic [CLS_W-1:0]  cls_idx;
   logic [FILL_W-1:0] fill_cur, fill_next, rd_slot, wr_slot;
   logic [MEM_AW-1:0] base, rd_addr, wr_addr;
   logic [BYTES_W-1:0] cost;
   logic fire, alloc, pooled, empty, full, hit, push;
   status_type status;

   assign fire    = item_valid && load;
   assign cls_idx = cls_info.cls[CLS_W-1:0];
   assign fill_cur = fill_ff[cls_idx];
   assign alloc   = cmd == CMD_ALLOC;
   assign pooled  = !cls_info.oversize;
   assign empty   = fill_cur == '0;
   assign full    = fill_cur == FILL_W'(ENTRIES_PER_CLASS);
   assign hit     = pooled && alloc && !empty;
   assign push    = pooled && !alloc;
   assign cost    = cls_info.csize + BYTES_W'(overhead);

   assign rd_slot = fill_cur - FILL_W'(1);
   assign wr_slot = full ? FILL_W'(ENTRIES_PER_CLASS - 1) : fill_cur;
   assign base    = MEM_AW'(MEM_AW'(cls_idx) * MEM_AW'(ENTRIES_PER_CLASS));
   assign rd_addr = base + MEM_AW'(rd_slot[SLOT_W-1:0]);
   assign wr_addr = base + MEM_AW'(wr_slot[SLOT_W-1:0]);

   always_comb begin
      fill_next  = fill_cur;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      entries_in = entries_ff;
      bytes_in   = bytes_ff;
      priority if (cls_info.oversize) begin
         status = alloc ? ST_ALLOC_OVERSIZE : ST_FREE_OVERSIZE;
         if (alloc) begin
            misses_in = misses_ff + CNT_W'(1);
         end
      end else if (alloc) begin
         if (empty) begin
            status    = ST_ALLOC_MISS;
            misses_in = misses_ff + CNT_W'(1);
         end else begin
            status     = ST_ALLOC_HIT;
            fill_next  = fill_cur - FILL_W'(1);
            hits_in    = hits_ff + CNT_W'(1);
            entries_in = entries_ff - ENT_W'(1);
            bytes_in   = bytes_ff - cost;
         end
      end else begin
         if (full) begin
            status = ST_FREE_EVICT;
         end else begin
            status     = ST_FREE_CACHED;
            fill_next  = fill_cur + FILL_W'(1);
            entries_in = entries_ff + ENT_W'(1);
            bytes_in   = bytes_ff + cost;
         end
      end
   end

   always_comb begin
      res_in.status     = status;
      res_in.use_mem    = hit || (push && full);
      res_in.pass_addr  = (cls_info.oversize && !alloc) ? OUT_ADDR_W'(addr) : '0;
      res_in.class_size = SIZE_W'(cls_info.csize);
      res_in.hits       = hits_in;
      res_in.misses     = misses_in;
      res_in.entries    = ENTRIES_W'(entries_in);
      res_in.bytes      = bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            fill_ff[i] <= '0;
         end
         hits_ff    <= '0;
         misses_ff  <= '0;
         entries_ff <= '0;
         bytes_ff   <= '0;
      end else if (fire) begin
         fill_ff[cls_idx] <= fill_next;
         hits_ff          <= hits_in;
         misses_ff        <= misses_in;
         entries_ff       <= entries_in;
         bytes_ff         <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && push) begin
         mem[wr_addr] <= addr;
      end
      if (load) begin
         rd_ff  <= mem[rd_addr];
         res_ff <= res_in;
      end
   end

   assign rd_data = rd_ff;
   assign res     = res_ff;

endmodule

// ===== hdl/size_class_stack_cache_top.sv =====
// Top level of the size class stack cache: input, middle and result stages.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | cmd, req_size, buf_addr
//   rsp     | out       | rsp_valid / rsp_stall  | status, out_addr, class_size, counts
//   csr     | in        | csr_valid / csr_ready  | entry_overhead_bytes
//
// One item per cycle while rsp_stall is low; results pass the middle and result stages.
// The stack memory has one write and one registered read port, both used in the
// cycle an item leaves the input stage, so the next item sees its update.
// Reset clears fill counts, counters and pipeline valids; overhead returns to 256.
// A stalled result backs up through the stages and raises req_stall only when all
// three stages hold items.
module size_class_stack_cache_top
   import scsc_pkg::*;
#(
   parameter int MIN_SHIFT         = 12,
   parameter int NUM_CLASSES       = 8,
   parameter int ENTRIES_PER_CLASS = 16,
   parameter int ADDR_BITS         = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [SIZE_W-1:0]     req_req_size,
   input  logic [OUT_ADDR_W-1:0] req_buf_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [OUT_ADDR_W-1:0] rsp_out_addr,
   output logic [SIZE_W-1:0]     rsp_class_size,
   output logic [CNT_W-1:0]      rsp_hit_count,
   output logic [CNT_W-1:0]      rsp_miss_count,
   output logic [ENTRIES_W-1:0]  rsp_cached_entries,
   output logic [BYTES_W-1:0]    rsp_cached_bytes,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [OVH_W-1:0]      csr_entry_overhead_bytes
);

   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   cmd_type               cmd_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [OUT_ADDR_W-1:0] addr_ff;
   logic [OVH_W-1:0]      ovh_ff;

   scsc_class_type        cls_info;
   scsc_res_type          res;
   logic [ADDR_BITS-1:0]  rd_data;
   logic [OUT_ADDR_W-1:0] out_addr_in;
   scsc_res_type          out_ff;
   logic [OUT_ADDR_W-1:0] out_addr_ff;

   assign adv3      = !v3_ff || !rsp_stall;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         ovh_ff <= OVH_RESET;
      end else begin
         if (adv1) begin
            v1_ff <= req_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (csr_valid && csr_ready) begin
            ovh_ff <= csr_entry_overhead_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         cmd_ff  <= cmd_type'(req_cmd);
         size_ff <= req_req_size;
         addr_ff <= req_buf_addr;
      end
   end

   scsc_classify #(
      .MIN_SHIFT   (MIN_SHIFT),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_classify (
      .size     (size_ff),
      .cls_info (cls_info)
   );

   scsc_stack #(
      .NUM_CLASSES       (NUM_CLASSES),
      .ENTRIES_PER_CLASS (ENTRIES_PER_CLASS),
      .ADDR_BITS         (ADDR_BITS)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .load       (adv2),
      .item_valid (v1_ff),
      .cmd        (cmd_ff),
      .cls_info   (cls_info),
      .addr       (ADDR_BITS'(addr_ff)),
      .overhead   (ovh_ff),
      .rd_data    (rd_data),
      .res        (res)
   );

   assign out_addr_in = res.use_mem ? OUT_ADDR_W'(rd_data) : res.pass_addr;

   always_ff @(posedge clock) begin
      if (adv3) begin
         out_ff      <= res;
         out_addr_ff <= out_addr_in;
      end
   end

   assign rsp_valid          = v3_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_out_addr       = out_addr_ff;
   assign rsp_class_size     = out_ff.class_size;
   assign rsp_hit_count      = out_ff.hits;
   assign rsp_miss_count     = out_ff.misses;
   assign rsp_cached_entries = out_ff.entries;
   assign rsp_cached_bytes   = out_ff.bytes;

endmodule

// ===== hdl/scsc_checker.sv =====
// Port-level assertions for the size class stack cache, bound to the top level.
module scsc_checker
   import scsc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [2:0]            rsp_status,
   input logic [OUT_ADDR_W-1:0] rsp_out_addr,
   input logic [CNT_W-1:0]      rsp_hit_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_addr))
      else $error("result item changed while stalled");

   a_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ALLOC_MISS || rsp_status == ST_ALLOC_OVERSIZE ||
                    rsp_status == ST_FREE_CACHED)
      |-> rsp_out_addr == '0)
      else $error("nonzero address on a status without one");

   a_hit_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 (rsp_valid && !rsp_stall && rsp_status == ST_ALLOC_HIT)
      |-> rsp_hit_count == CNT_W'($past(rsp_hit_count) + CNT_W'(1)))
      else $error("hit count did not advance by one on a hit");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no result pending");

endmodule

bind size_class_stack_cache_top scsc_checker u_scsc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_out_addr  (rsp_out_addr),
   .rsp_hit_count (rsp_hit_count)
);

// ===== dv/size_class_stack_cache_top_tb.sv =====
// Self-checking testbench for the size class stack cache: directed rows, then random phases.
`timescale 1ns / 1ps

module size_class_stack_cache_top_tb;
   import scsc_pkg::*;

   localparam int MIN_SHIFT   = 12;
   localparam int NUM_CLASSES = 8;
   localparam int CLASS_DEPTH = 16;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 406;
   localparam int NUM_PHASES  = 4;
   localparam logic [SIZE_W-1:0] MAX_POOLED = 32'd1 << (MIN_SHIFT + NUM_CLASSES - 1);
   localparam int PHASE_FREE_PCT [NUM_PHASES] = '{70, 25, 55, 50};

   typedef struct packed {
      status_type            status;
      logic [OUT_ADDR_W-1:0] addr;
      logic [SIZE_W-1:0]     csize;
      logic [CNT_W-1:0]      hits;
      logic [CNT_W-1:0]      misses;
      logic [ENTRIES_W-1:0]  entries;
      logic [BYTES_W-1:0]    bytes;
   } cache_reply_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [SIZE_W-1:0]     size;
      logic [OUT_ADDR_W-1:0] addr;
      logic [4:0]            reps;
      logic                  typed;
      cache_reply_type       want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   cmd_type               req_cmd;
   logic [SIZE_W-1:0]     req_req_size;
   logic [OUT_ADDR_W-1:0] req_buf_addr;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [2:0]            rsp_status;
   logic [OUT_ADDR_W-1:0] rsp_out_addr;
   logic [SIZE_W-1:0]     rsp_class_size;
   logic [CNT_W-1:0]      rsp_hit_count;
   logic [CNT_W-1:0]      rsp_miss_count;
   logic [ENTRIES_W-1:0]  rsp_cached_entries;
   logic [BYTES_W-1:0]    rsp_cached_bytes;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [OVH_W-1:0]      csr_entry_overhead_bytes;

   logic [OUT_ADDR_W-1:0] stack_mem [NUM_CLASSES][CLASS_DEPTH];
   int                    stack_fill [NUM_CLASSES];
   logic [CNT_W-1:0]      hit_total;
   logic [CNT_W-1:0]      miss_total;
   logic [ENTRIES_W-1:0]  entry_total;
   logic [BYTES_W-1:0]    byte_total;
   logic [OVH_W-1:0]      overhead;

   cache_reply_type       pending_replies [$];
   cache_reply_type       front_reply;
   dir_row_type           dir_rows [$];
   int                    err_count;
   bit                    quiet;
   bit                    hold_off_req;

   size_class_stack_cache_top i_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_cmd                  (req_cmd),
      .req_req_size             (req_req_size),
      .req_buf_addr             (req_buf_addr),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_out_addr             (rsp_out_addr),
      .rsp_class_size           (rsp_class_size),
      .rsp_hit_count            (rsp_hit_count),
      .rsp_miss_count           (rsp_miss_count),
      .rsp_cached_entries       (rsp_cached_entries),
      .rsp_cached_bytes         (rsp_cached_bytes),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_entry_overhead_bytes (csr_entry_overhead_bytes)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic cache_reply_type apply_cache_op(input cmd_type c,
                                                       input logic [SIZE_W-1:0] sz,
                                                       input logic [OUT_ADDR_W-1:0] ad);
      cache_reply_type   rep;
      logic [SIZE_W-1:0] rounded;
      logic [BYTES_W-1:0] cost;
      int                cls;
      rep = '0;
      if (sz > MAX_POOLED) begin
         rep.csize = sz;
         if (c == CMD_ALLOC) begin
            miss_total++;
            rep.status = ST_ALLOC_OVERSIZE;
         end else begin
            rep.addr   = ad;
            rep.status = ST_FREE_OVERSIZE;
         end
      end else begin
         rounded = 32'd1 << MIN_SHIFT;
         cls     = 0;
         while (rounded < sz) begin
            rounded = rounded << 1;
            cls++;
         end
         rep.csize = rounded;
         cost      = BYTES_W'(rounded) + BYTES_W'(overhead);
         if (c == CMD_ALLOC) begin
            if (stack_fill[cls] > 0) begin
               stack_fill[cls]--;
               rep.addr = stack_mem[cls][stack_fill[cls]];
               entry_total--;
               byte_total -= cost;
               hit_total++;
               rep.status = ST_ALLOC_HIT;
            end else begin
               miss_total++;
               rep.status = ST_ALLOC_MISS;
            end
         end else begin
            rep.status = ST_FREE_CACHED;
            if (stack_fill[cls] >= CLASS_DEPTH) begin
               stack_fill[cls] = CLASS_DEPTH - 1;
               rep.addr = stack_mem[cls][stack_fill[cls]];
               entry_total--;
               byte_total -= cost;
               rep.status = ST_FREE_EVICT;
            end
            stack_mem[cls][stack_fill[cls]] = ad;
            stack_fill[cls]++;
            entry_total++;
            byte_total += cost;
         end
      end
      rep.hits    = hit_total;
      rep.misses  = miss_total;
      rep.entries = entry_total;
      rep.bytes   = byte_total;
      return rep;
   endfunction

   function automatic int idle_len();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         err_count++;
      end
   endtask

   task automatic issue_item(input cmd_type c, input logic [SIZE_W-1:0] sz,
                             input logic [OUT_ADDR_W-1:0] ad, input bit use_typed,
                             input cache_reply_type typed_reply);
      cache_reply_type rep;
      int              gap;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_cmd      <= c;
      req_req_size <= sz;
      req_buf_addr <= ad;
      do @(posedge clock); while (req_stall);
      rep = apply_cache_op(c, sz, ad);
      pending_replies.push_back(use_typed ? typed_reply : rep);
      gap = idle_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_overhead(input logic [OVH_W-1:0] v);
      @(negedge clock);
      csr_valid                <= 1'b1;
      csr_entry_overhead_bytes <= v;
      do @(posedge clock); while (!csr_ready);
      overhead = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("result item with no expectation waiting");
            err_count++;
         end else begin
            front_reply = pending_replies.pop_front();
            check_field("status", front_reply.status, rsp_status);
            check_field("out_addr", front_reply.addr, rsp_out_addr);
            check_field("class_size", front_reply.csize, rsp_class_size);
            check_field("hit_count", front_reply.hits, rsp_hit_count);
            check_field("miss_count", front_reply.misses, rsp_miss_count);
            check_field("cached_entries", front_reply.entries, rsp_cached_entries);
            check_field("cached_bytes", front_reply.bytes, rsp_cached_bytes);
         end
      end
   end

   initial begin
      int                    run;
      logic                  level;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            level = !quiet && ($urandom_range(0, 99) < 35);
            run   = idle_len() + 1;
            @(negedge clock);
            rsp_stall <= level;
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      cmd_type               c;
      logic [SIZE_W-1:0]     sz;
      logic [OUT_ADDR_W-1:0] ad;
      int                    k;
      int                    sel;
      reset                    = 1'b1;
      req_valid                = 1'b0;
      req_cmd                  = CMD_ALLOC;
      req_req_size             = '0;
      req_buf_addr             = '0;
      rsp_stall                = 1'b0;
      csr_valid                = 1'b0;
      csr_entry_overhead_bytes = '0;
      err_count                = 0;
      quiet                    = 1'b0;
      hold_off_req             = 1'b0;
      hit_total                = '0;
      miss_total               = '0;
      entry_total              = '0;
      byte_total               = '0;
      overhead                 = OVH_RESET;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         stack_fill[i] = 0;
      end

      dir_rows.push_back('{CMD_ALLOC, 32'd0, 48'd0, 5'd1, 1'b1,
         '{ST_ALLOC_MISS, 48'd0, 32'd4096, 32'd0, 32'd1, 8'd0, 40'd0}});
      dir_rows.push_back('{CMD_ALLOC, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 5'd1, 1'b1,
         '{ST_ALLOC_OVERSIZE, 48'd0, 32'hFFFF_FFFF, 32'd0, 32'd2, 8'd0, 40'd0}});
      dir_rows.push_back('{CMD_FREE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 5'd1, 1'b1,
         '{ST_FREE_OVERSIZE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd2, 8'd0, 40'd0}});
      dir_rows.push_back('{CMD_FREE, 32'd4096, 48'd0, 5'd1, 1'b1,
         '{ST_FREE_CACHED, 48'd0, 32'd4096, 32'd0, 32'd2, 8'd1, 40'd4352}});
      dir_rows.push_back('{CMD_ALLOC, 32'd1, 48'h5555_5555_5555, 5'd1, 1'b1,
         '{ST_ALLOC_HIT, 48'd0, 32'd4096, 32'd1, 32'd2, 8'd0, 40'd0}});
      dir_rows.push_back('{CMD_FREE, 32'd4097, 48'hFFFF_FFFF_FFFF, 5'd1, 1'b0, '0});
      dir_rows.push_back('{CMD_FREE, 32'd524288, 48'hAAAA_AAAA_AAAA, 5'd1, 1'b0, '0});
      dir_rows.push_back('{CMD_ALLOC, 32'd524289, 48'd0, 5'd1, 1'b0, '0});
      dir_rows.push_back('{CMD_ALLOC, 32'd262145, 48'd0, 5'd1, 1'b0, '0});
      dir_rows.push_back('{CMD_FREE, 32'd16384, 48'h1000_0000_0000, 5'd17, 1'b0, '0});
      dir_rows.push_back('{CMD_ALLOC, 32'd16383, 48'd0, 5'd1, 1'b0, '0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         for (int n = 0; n < dir_rows[r].reps; n++) begin
            issue_item(dir_rows[r].cmd, dir_rows[r].size,
                       dir_rows[r].addr + OUT_ADDR_W'(n) * 48'h1000,
                       dir_rows[r].typed, dir_rows[r].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_replies();
         case (p)
            0: write_overhead(16'd0);
            1: write_overhead(16'hFFFF);
            2: write_overhead(OVH_W'($urandom_range(1, 65534)));
            default: write_overhead(OVH_RESET);
         endcase
         quiet        = (p == 2);
         hold_off_req = (p == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            c   = ($urandom_range(0, 99) < PHASE_FREE_PCT[p]) ? CMD_FREE : CMD_ALLOC;
            sel = $urandom_range(0, 99);
            k   = $urandom_range(0, NUM_CLASSES - 1);
            if (sel < 3) begin
               sz = (sel == 0) ? 32'hFFFF_FFFF : MAX_POOLED + 32'd1;
            end else if (sel < 8) begin
               do sz = $urandom; while (sz <= MAX_POOLED);
            end else if (sel < 20) begin
               sz = 32'd1 << (MIN_SHIFT + k);
            end else if (k == 0) begin
               sz = $urandom_range(0, 32'd1 << MIN_SHIFT);
            end else begin
               sz = $urandom_range((32'd1 << (MIN_SHIFT - 1 + k)) + 32'd1,
                                   32'd1 << (MIN_SHIFT + k));
            end
            ad = OUT_ADDR_W'({$urandom, $urandom});
            issue_item(c, sz, ad, 1'b0, '0);
         end
      end

      drain_replies();
      quiet = 1'b1;
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
